FILE: hw/rtl/smea_pkg.sv
package smea_pkg;

  // Field widths of the item payloads
  localparam int ROW_W  = 11;
  localparam int COL_W  = 10;
  localparam int TPOS_W = 14;
  localparam int DATA_W = 40;

  // Word width of the index memory (row-start pointers and column indices)
  localparam int IDX_W  = 14;

  typedef enum logic [1:0] {
    MODE_LOAD_ROW = 2'd0,
    MODE_LOAD_COL = 2'd1,
    MODE_ADD      = 2'd2,
    MODE_READ     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_SAT    = 2'd2
  } status_t;

  typedef struct packed {
    mode_t                    mode;
    logic [ROW_W-1:0]         row_number;
    logic [COL_W-1:0]         column_number;
    logic [TPOS_W-1:0]        table_position;
    logic signed [DATA_W-1:0] addend;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] entry_value;
    status_t                  status;
  } out_item_t;

endpackage

FILE: hw/rtl/sparse_matrix_element_accumulate_unit.sv
// Sparse matrix element accumulator, row-compressed storage.
// Input channel in_valid/in_ready/in_data carries one item: load a row-start
// pointer, load a column index, add a value at (row, column) with saturation,
// or read the value at (row, column). Each item gives one result on
// out_valid/out_ready/out_data: the entry value and a status (ok, not in the
// sparsity pattern, saturated).
// One item is worked on at a time. Loads and out-of-range requests go
// straight to the finish step. A diagonal add or read reads its value entry
// and then finishes. An off-diagonal add or read first fetches the row's
// pointer pair, then runs a binary search of k steps, k at most
// ceil(log2(row length)) + 1 (14 for a row spanning 8192 entries), then the value.
// The search bound comes from the index memory: each step is one two-address
// read of the column table and one compare. The next item is accepted
// the cycle after its predecessor's result is registered.
// A result waiting in the output register does not block the next item; a
// finished result holds in the block only while the output register is full.
// After reset the value memory is swept to zero, one entry a cycle, over all
// 2*OFFDIAG_ENTRIES + MATRIX_ROWS entries (17408 at defaults); in_ready stays
// low meanwhile. Pointer and column entries must be loaded before use.
module sparse_matrix_element_accumulate_unit #(
  parameter int MATRIX_ROWS     = 1024,
  parameter int OFFDIAG_ENTRIES = 8192,
  parameter int VALUE_BITS      = 40
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  smea_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output smea_pkg::out_item_t  out_data
);

  import smea_pkg::*;

  // Index memory: row_start at [0, ROWS], column table after it
  localparam int IDX_DEPTH  = MATRIX_ROWS + 1 + OFFDIAG_ENTRIES;
  // Value memory: lower, then upper, then diagonal
  localparam int VAL_DEPTH  = 2 * OFFDIAG_ENTRIES + MATRIX_ROWS;
  localparam int IAW        = $clog2(IDX_DEPTH);
  localparam int VAW        = $clog2(VAL_DEPTH);
  localparam int PAW        = (OFFDIAG_ENTRIES > 1) ? $clog2(OFFDIAG_ENTRIES) : 1;
  localparam int COL_BASE   = MATRIX_ROWS + 1;
  localparam int UPPER_BASE = OFFDIAG_ENTRIES;
  localparam int DIAG_BASE  = 2 * OFFDIAG_ENTRIES;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_PTR,
    S_SRD,
    S_SEV,
    S_VAL,
    S_FIN
  } state_t;

  state_t                state_r, state_nxt;
  logic [VAW-1:0]        clr_r, clr_nxt;
  mode_t                 mode_r, mode_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic [TPOS_W-1:0]     tpos_r, tpos_nxt;
  logic [VALUE_BITS-1:0] addend_r, addend_nxt;
  logic [ROW_W-1:0]      big_r, big_nxt;
  logic [COL_W-1:0]      small_r, small_nxt;
  logic                  upper_r, upper_nxt;
  logic [PAW-1:0]        lo_r, lo_nxt;
  logic [PAW-1:0]        hi_r, hi_nxt;
  logic [PAW-1:0]        mid_r, mid_nxt;
  logic [VAW-1:0]        vaddr_r, vaddr_nxt;
  out_item_t             res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r, out_item_nxt;

  // Memory ports
  logic                       idx_we;
  logic [IAW-1:0]             idx_waddr;
  logic [IDX_W-1:0]           idx_wdata;
  logic [1:0][IAW-1:0]        idx_raddr;
  logic [1:0][IDX_W-1:0]      idx_rd;
  logic                       val_we;
  logic [VAW-1:0]             val_waddr;
  logic [VALUE_BITS-1:0]      val_wdata;
  logic [0:0][VAW-1:0]        val_raddr;
  logic [0:0][VALUE_BITS-1:0] val_rd;

  // Datapath temporaries
  logic [VALUE_BITS+DATA_W-1:0] add_ext;
  logic [VALUE_BITS:0]          sum;
  logic                         ovf;
  logic [VALUE_BITS-1:0]        new_val;
  logic [VALUE_BITS-1:0]        res_val;
  logic [VALUE_BITS+DATA_W-1:0] res_ext;
  logic [IDX_W-1:0]             hi_m1;
  logic [PAW-1:0]               mid_calc;
  logic [VAW-1:0]               hit_addr;

  smea_ram #(
    .WIDTH    (IDX_W),
    .DEPTH    (IDX_DEPTH),
    .RD_PORTS (2)
  ) u_idx_ram (
    .clk     (clk),
    .wr_en   (idx_we),
    .wr_addr (idx_waddr),
    .wr_data (idx_wdata),
    .rd_addr (idx_raddr),
    .rd_data (idx_rd)
  );

  smea_ram #(
    .WIDTH    (VALUE_BITS),
    .DEPTH    (VAL_DEPTH),
    .RD_PORTS (1)
  ) u_val_ram (
    .clk     (clk),
    .wr_en   (val_we),
    .wr_addr (val_waddr),
    .wr_data (val_wdata),
    .rd_addr (val_raddr),
    .rd_data (val_rd)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // Saturating add of the stored value and the addend
  always_comb begin
    sum = {val_rd[0][VALUE_BITS-1], val_rd[0]} + {addend_r[VALUE_BITS-1], addend_r};
    ovf = sum[VALUE_BITS] ^ sum[VALUE_BITS-1];
    if (!ovf) begin
      new_val = sum[VALUE_BITS-1:0];
    end else if (sum[VALUE_BITS]) begin
      new_val = {1'b1, {(VALUE_BITS-1){1'b0}}};
    end else begin
      new_val = {1'b0, {(VALUE_BITS-1){1'b1}}};
    end
  end

  // Search midpoint and hit address
  always_comb begin
    if (lo_r >= hi_r) begin
      mid_calc = lo_r;
    end else begin
      mid_calc = lo_r + ((hi_r - lo_r) >> 1);
    end
    hit_addr = upper_r ? (VAW'(UPPER_BASE) + VAW'(lo_r)) : VAW'(lo_r);
    hi_m1    = idx_rd[1] - IDX_W'(1);
  end

  // Sequencer next state and memory control
  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    mode_nxt     = mode_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    tpos_nxt     = tpos_r;
    addend_nxt   = addend_r;
    big_nxt      = big_r;
    small_nxt    = small_r;
    upper_nxt    = upper_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    mid_nxt      = mid_r;
    vaddr_nxt    = vaddr_r;
    res_nxt      = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt = out_item_r;

    idx_we       = 1'b0;
    idx_waddr    = '0;
    idx_wdata    = '0;
    idx_raddr[0] = '0;
    idx_raddr[1] = '0;
    val_we       = 1'b0;
    val_waddr    = vaddr_r;
    val_wdata    = new_val;
    val_raddr[0] = '0;

    add_ext = {{VALUE_BITS{1'b0}}, in_data.addend};
    res_val = val_rd[0];
    res_ext = {{DATA_W{1'b0}}, res_val};

    unique case (state_r)
      // Zero the value memory after reset
      S_CLEAR: begin
        val_we    = 1'b1;
        val_waddr = clr_r;
        val_wdata = '0;
        clr_nxt   = clr_r + VAW'(1);
        if (clr_r == VAW'(VAL_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // Take a new item
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt   = in_data.mode;
          row_nxt    = in_data.row_number;
          col_nxt    = in_data.column_number;
          tpos_nxt   = in_data.table_position;
          addend_nxt = add_ext[VALUE_BITS-1:0];
          upper_nxt  = (ROW_W'(in_data.column_number) > in_data.row_number);
          if (upper_nxt) begin
            big_nxt   = ROW_W'(in_data.column_number);
            small_nxt = COL_W'(in_data.row_number);
          end else begin
            big_nxt   = in_data.row_number;
            small_nxt = in_data.column_number;
          end
          state_nxt = S_START;
        end
      end

      // Decode: loads, range check, diagonal or pointer fetch
      S_START: begin
        res_nxt.entry_value = '0;
        res_nxt.status      = ST_OK;
        state_nxt           = S_FIN;
        unique case (mode_r) inside
          MODE_LOAD_ROW: begin
            if (32'(row_r) <= MATRIX_ROWS) begin
              idx_we    = 1'b1;
              idx_waddr = IAW'(row_r);
              idx_wdata = IDX_W'(tpos_r);
            end
          end
          MODE_LOAD_COL: begin
            if (32'(tpos_r) < OFFDIAG_ENTRIES) begin
              idx_we    = 1'b1;
              idx_waddr = IAW'(COL_BASE) + IAW'(tpos_r);
              idx_wdata = IDX_W'(col_r);
            end
          end
          MODE_ADD, MODE_READ: begin
            if (32'(row_r) >= MATRIX_ROWS || 32'(col_r) >= MATRIX_ROWS) begin
              res_nxt.status = ST_ABSENT;
            end else if (ROW_W'(col_r) == row_r) begin
              vaddr_nxt    = VAW'(DIAG_BASE) + VAW'(row_r);
              val_raddr[0] = vaddr_nxt;
              state_nxt    = S_VAL;
            end else begin
              idx_raddr[0] = IAW'(big_r);
              idx_raddr[1] = IAW'(big_r) + IAW'(1);
              state_nxt    = S_PTR;
            end
          end
        endcase
      end

      // Row range from the pointer pair
      S_PTR: begin
        if (idx_rd[1] == '0 || idx_rd[0] >= idx_rd[1] ||
            32'(idx_rd[0]) >= OFFDIAG_ENTRIES) begin
          res_nxt.entry_value = '0;
          res_nxt.status      = ST_ABSENT;
          state_nxt           = S_FIN;
        end else begin
          lo_nxt = PAW'(idx_rd[0]);
          if (32'(hi_m1) >= OFFDIAG_ENTRIES) begin
            hi_nxt = PAW'(OFFDIAG_ENTRIES - 1);
          end else begin
            hi_nxt = PAW'(hi_m1);
          end
          state_nxt = S_SRD;
        end
      end

      // Fetch column[lo] and column[mid]
      S_SRD: begin
        idx_raddr[0] = IAW'(COL_BASE) + IAW'(lo_r);
        idx_raddr[1] = IAW'(COL_BASE) + IAW'(mid_calc);
        mid_nxt      = mid_calc;
        state_nxt    = S_SEV;
      end

      // Compare and narrow
      S_SEV: begin
        if (idx_rd[0][COL_W-1:0] == small_r) begin
          vaddr_nxt    = hit_addr;
          val_raddr[0] = hit_addr;
          state_nxt    = S_VAL;
        end else if (lo_r >= hi_r) begin
          res_nxt.entry_value = '0;
          res_nxt.status      = ST_ABSENT;
          state_nxt           = S_FIN;
        end else begin
          if (idx_rd[1][COL_W-1:0] < small_r) begin
            lo_nxt = mid_r + PAW'(1);
          end else begin
            hi_nxt = mid_r;
          end
          state_nxt = S_SRD;
        end
      end

      // Read of the value entry, or read-modify-write for an add
      S_VAL: begin
        if (mode_r == MODE_ADD) begin
          val_we         = 1'b1;
          res_val        = new_val;
          res_nxt.status = ovf ? ST_SAT : ST_OK;
        end else begin
          res_nxt.status = ST_OK;
        end
        res_ext             = {{DATA_W{1'b0}}, res_val};
        res_nxt.entry_value = res_ext[DATA_W-1:0];
        state_nxt           = S_FIN;
      end

      // Hand the result to the output register
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r     <= mode_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    tpos_r     <= tpos_nxt;
    addend_r   <= addend_nxt;
    big_r      <= big_nxt;
    small_r    <= small_nxt;
    upper_r    <= upper_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    vaddr_r    <= vaddr_nxt;
    res_r      <= res_nxt;
    out_item_r <= out_item_nxt;
  end

  // An accepted item always enters decode
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_START))
    else $error("accepted item did not enter decode");

  // Search window never inverts
  a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRD) |-> (lo_r <= hi_r))
    else $error("search window inverted");

  // Search stays inside the column table
  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRD) |-> (32'(hi_r) < OFFDIAG_ENTRIES))
    else $error("search bound past column table");

  // A missing entry reports zero
  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_ABSENT) |-> (out_data.entry_value == '0))
    else $error("absent entry with nonzero value");

  // New results come only from the finish step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_FIN))
    else $error("result raised outside finish step");

endmodule

FILE: hw/rtl/smea_ram.sv
module smea_ram #(
  parameter int WIDTH    = 8,
  parameter int DEPTH    = 16,
  parameter int RD_PORTS = 1
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [$clog2(DEPTH)-1:0]                wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [RD_PORTS-1:0][$clog2(DEPTH)-1:0]  rd_addr,
  output logic [RD_PORTS-1:0][WIDTH-1:0]          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read ports
  for (genvar p = 0; p < RD_PORTS; p++) begin : g_rd
    always_ff @(posedge clk) begin
      rd_data[p] <= mem[rd_addr[p]];
    end
  end

endmodule

FILE: dv/smea_entry_checker.sv
`timescale 1ns / 1ps

module smea_entry_checker #(
  parameter int NUM_ROWS  = 1024,
  parameter int NUM_SLOTS = 8192
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  smea_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  smea_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending
);
  import smea_pkg::*;

  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum {LOC_DIAG, LOC_LOWER, LOC_UPPER} entry_loc_t;

  // Own copy of the matrix storage
  logic signed [DATA_W-1:0] diag_mem  [NUM_ROWS];
  logic signed [DATA_W-1:0] lower_mem [NUM_SLOTS];
  logic signed [DATA_W-1:0] upper_mem [NUM_SLOTS];
  logic [TPOS_W-1:0]        ptr_mem   [NUM_ROWS+1];
  logic [COL_W-1:0]         col_mem   [NUM_SLOTS];

  out_item_t expected_entries [$];

  // Binary search for col_key among the column indices of row row_key
  function automatic bit find_slot(input int row_key, input int col_key, output int slot);
    int lo;
    int hi;
    int hix;
    int mid;
    slot = 0;
    lo = ptr_mem[row_key];
    hix = ptr_mem[row_key+1];
    if (hix == 0 || lo >= hix || lo >= NUM_SLOTS) return 1'b0;
    hi = hix - 1;
    if (hi >= NUM_SLOTS) hi = NUM_SLOTS - 1;
    forever begin
      if (col_mem[lo] == col_key) begin
        slot = lo;
        return 1'b1;
      end
      if (lo >= hi) return 1'b0;
      mid = lo + (hi - lo) / 2;
      if (col_mem[mid] < col_key) lo = mid + 1;
      else hi = mid;
    end
  endfunction

  // Apply one item to the storage copy and return the result it gives
  function automatic out_item_t predict_entry(input in_item_t it);
    out_item_t res;
    int r;
    int c;
    int slot;
    bit found;
    entry_loc_t loc;
    logic signed [DATA_W-1:0] cur;
    logic [DATA_W:0] sum;
    res.entry_value = '0;
    res.status = ST_OK;
    r = it.row_number;
    c = it.column_number;
    slot = 0;
    case (it.mode)
      MODE_LOAD_ROW: begin
        if (r <= NUM_ROWS) ptr_mem[r] = it.table_position;
      end
      MODE_LOAD_COL: begin
        if (it.table_position < NUM_SLOTS) col_mem[it.table_position] = it.column_number;
      end
      default: begin
        if (r >= NUM_ROWS || c >= NUM_ROWS) begin
          res.status = ST_ABSENT;
        end else begin
          found = 1'b1;
          loc = LOC_DIAG;
          cur = '0;
          if (r == c) begin
            cur = diag_mem[r];
          end else if (r > c) begin
            found = find_slot(r, c, slot);
            loc = LOC_LOWER;
            if (found) cur = lower_mem[slot];
          end else begin
            found = find_slot(c, r, slot);
            loc = LOC_UPPER;
            if (found) cur = upper_mem[slot];
          end
          if (!found) begin
            res.status = ST_ABSENT;
          end else begin
            if (it.mode == MODE_ADD) begin
              sum = {cur[DATA_W-1], cur} + {it.addend[DATA_W-1], it.addend};
              if (sum[DATA_W] != sum[DATA_W-1]) begin
                cur = sum[DATA_W] ? VAL_MIN : VAL_MAX;
                res.status = ST_SAT;
              end else begin
                cur = sum[DATA_W-1:0];
              end
              case (loc)
                LOC_DIAG:  diag_mem[r] = cur;
                LOC_LOWER: lower_mem[slot] = cur;
                default:   upper_mem[slot] = cur;
              endcase
            end
            res.entry_value = cur;
          end
        end
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("%0t: %s mismatch, expected %h got %h", $time, field, want, got);
    fail_count++;
  endtask

  // Compare each result with the oldest expectation, then queue new items
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_ROWS; i++) diag_mem[i] = '0;
      for (int i = 0; i <= NUM_ROWS; i++) ptr_mem[i] = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        lower_mem[i] = '0;
        upper_mem[i] = '0;
        col_mem[i] = '0;
      end
      expected_entries.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_entries.size() == 0) begin
          report_mismatch("unexpected result", 64'(0), 64'(out_data));
        end else begin
          want = expected_entries.pop_front();
          if (out_data.entry_value !== want.entry_value)
            report_mismatch("entry_value", 64'(want.entry_value),
                            64'(out_data.entry_value));
          if (out_data.status !== want.status)
            report_mismatch("status", 64'(want.status), 64'(out_data.status));
        end
      end
      if (in_valid && in_ready) expected_entries.push_back(predict_entry(in_data));
      pending <= expected_entries.size();
    end
  end

endmodule

FILE: dv/sparse_matrix_element_accumulate_unit_tb.sv
`timescale 1ns / 1ps

module sparse_matrix_element_accumulate_unit_tb;
  import smea_pkg::*;

  localparam int NUM_ROWS       = 1024;
  localparam int NUM_SLOTS      = 8192;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int BAND_PERIOD    = 140;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int MAX_BAND_ROWS  = 8;
  localparam int MAX_ROW_LEN    = 6;

  localparam logic [DATA_W-1:0] ADD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] ADD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int fail_count;
  int pending;
  int idle_cycles;
  bit steady;

  // What has been loaded so far, so that no search touches an unloaded entry
  int rs_sh  [NUM_ROWS+1];
  bit rs_set [NUM_ROWS+1];
  int col_sh [NUM_SLOTS];
  bit col_set[NUM_SLOTS];

  // Current band of rows with a well-formed sparsity pattern
  int band_first;
  int band_count;
  int band_len [MAX_BAND_ROWS];
  int band_cols[MAX_BAND_ROWS][MAX_ROW_LEN];

  sparse_matrix_element_accumulate_unit #(
    .MATRIX_ROWS    (NUM_ROWS),
    .OFFDIAG_ENTRIES(NUM_SLOTS),
    .VALUE_BITS     (DATA_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  smea_entry_checker #(
    .NUM_ROWS (NUM_ROWS),
    .NUM_SLOTS(NUM_SLOTS)
  ) entry_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Receiver stalls at random except in the steady stretch
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 31);
  end

  // Watchdog: too long without any item moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic in_item_t make_item(input mode_t m, input int r, input int c, input int tp,
                                         input logic [DATA_W-1:0] add);
    in_item_t it;
    it.mode = m;
    it.row_number = ROW_W'(r);
    it.column_number = COL_W'(c);
    it.table_position = TPOS_W'(tp);
    it.addend = add;
    return it;
  endfunction

  function automatic logic [DATA_W-1:0] random_addend();
    int t;
    t = $urandom_range(0, 9);
    if (t < 5) return DATA_W'({$urandom, $urandom});
    if (t < 8) begin
      t = $urandom_range(0, 4194304) - 2097152;
      return DATA_W'(t);
    end
    if (t == 8) return ADD_MAX - DATA_W'($urandom_range(0, 15));
    return ADD_MIN + DATA_W'($urandom_range(0, 15));
  endfunction

  function automatic mode_t pick_access();
    return ($urandom_range(0, 99) < 60) ? MODE_ADD : MODE_READ;
  endfunction

  // Walk the search path for (r, c) and tell whether every entry it reads is loaded
  function automatic bit search_stays_on_loaded(input int r, input int c);
    int big;
    int lesser;
    int lo;
    int hi;
    int hix;
    int mid;
    big = (r > c) ? r : c;
    lesser = (r > c) ? c : r;
    if (!rs_set[big] || !rs_set[big+1]) return 1'b0;
    lo = rs_sh[big];
    hix = rs_sh[big+1];
    if (hix == 0 || lo >= hix || lo >= NUM_SLOTS) return 1'b1;
    hi = hix - 1;
    if (hi >= NUM_SLOTS) hi = NUM_SLOTS - 1;
    forever begin
      if (!col_set[lo]) return 1'b0;
      if (col_sh[lo] == lesser) return 1'b1;
      if (lo >= hi) return 1'b1;
      mid = lo + (hi - lo) / 2;
      if (!col_set[mid]) return 1'b0;
      if (col_sh[mid] < lesser) lo = mid + 1;
      else hi = mid;
    end
  endfunction

  // Present one item at the falling edge and hold it until accepted
  task automatic push_item(input in_item_t it);
    if (it.mode == MODE_LOAD_ROW && it.row_number <= NUM_ROWS) begin
      rs_sh[it.row_number] = it.table_position;
      rs_set[it.row_number] = 1'b1;
    end
    if (it.mode == MODE_LOAD_COL && it.table_position < NUM_SLOTS) begin
      col_sh[it.table_position] = it.column_number;
      col_set[it.table_position] = 1'b1;
    end
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and wait until every expected result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  // Add or read at (r, c); a search that would hit unloaded entries becomes a diagonal access
  task automatic push_offdiag(input int r, input int c);
    mode_t m;
    m = pick_access();
    if (r == c || search_stays_on_loaded(r, c))
      push_item(make_item(m, r, c, $urandom_range(0, 16383), random_addend()));
    else
      push_item(make_item(m, r, r, $urandom_range(0, 16383), random_addend()));
  endtask

  // Load pointers and sorted column lists for a fresh band of rows
  task automatic build_band();
    int ptr[MAX_BAND_ROWS+1];
    int pos;
    int r;
    int lo_b;
    int hi_b;
    drain_results();
    band_count = $urandom_range(2, MAX_BAND_ROWS);
    band_first = $urandom_range(0, NUM_ROWS - band_count);
    if ($urandom_range(0, 99) < 80) pos = $urandom_range(0, NUM_SLOTS - 60);
    else pos = $urandom_range(NUM_SLOTS - 40, NUM_SLOTS - 1);
    for (int k = 0; k < band_count; k++) begin
      r = band_first + k;
      ptr[k] = pos;
      band_len[k] = $urandom_range(0, (r < MAX_ROW_LEN) ? r : MAX_ROW_LEN);
      lo_b = 0;
      for (int j = 0; j < band_len[k]; j++) begin
        hi_b = r - (band_len[k] - j);
        band_cols[k][j] = lo_b + $urandom_range(0, (hi_b - lo_b) / (band_len[k] - j));
        lo_b = band_cols[k][j] + 1;
      end
      pos += band_len[k];
    end
    ptr[band_count] = pos;
    for (int k = 0; k <= band_count; k++)
      push_item(make_item(MODE_LOAD_ROW, band_first + k, $urandom_range(0, 1023), ptr[k],
                          random_addend()));
    for (int k = 0; k < band_count; k++)
      for (int j = 0; j < band_len[k]; j++)
        push_item(make_item(MODE_LOAD_COL, $urandom_range(0, 2047), band_cols[k][j],
                            ptr[k] + j, random_addend()));
  endtask

  initial begin
    int done;
    int kind;
    int r;
    int c;
    int k;
    int lo;
    int hi;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    steady = 1'b0;
    idle_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Diagonal: zero after reset, saturation at both ends
    push_item(make_item(MODE_READ, 0, 0, 0, '0));
    push_item(make_item(MODE_ADD, 5, 5, 16383, ADD_MAX));
    push_item(make_item(MODE_ADD, 5, 5, 0, DATA_W'(1)));
    push_item(make_item(MODE_ADD, 6, 6, 0, ADD_MIN));
    push_item(make_item(MODE_ADD, 6, 6, 0, {DATA_W{1'b1}}));
    // Row out of range
    push_item(make_item(MODE_ADD, NUM_ROWS, 0, 0, ADD_MAX));
    push_item(make_item(MODE_READ, 2047, 1023, 16383, ADD_MIN));
    // Load slots past the end are ignored
    push_item(make_item(MODE_LOAD_ROW, NUM_ROWS + 1, 0, 100, '0));
    push_item(make_item(MODE_LOAD_ROW, 2047, 1023, 16383, '0));
    push_item(make_item(MODE_LOAD_COL, 0, 7, NUM_SLOTS, '0));
    push_item(make_item(MODE_LOAD_COL, 2047, 1023, 16383, '0));
    // Last row whose end pointer lies beyond the table, row before it empty
    push_item(make_item(MODE_LOAD_ROW, 1022, 0, NUM_SLOTS - 2, '0));
    push_item(make_item(MODE_LOAD_ROW, 1023, 0, NUM_SLOTS - 2, '0));
    push_item(make_item(MODE_LOAD_ROW, 1024, 0, 9000, '0));
    push_item(make_item(MODE_LOAD_COL, 0, 5, NUM_SLOTS - 2, '0));
    push_item(make_item(MODE_LOAD_COL, 0, 1022, NUM_SLOTS - 1, '0));
    push_item(make_item(MODE_ADD, 1023, 1022, 0, DATA_W'(40'h00_0012_3456)));
    push_item(make_item(MODE_ADD, 1022, 1023, 0, ADD_MIN));
    push_item(make_item(MODE_READ, 1023, 5, 0, '0));
    push_item(make_item(MODE_READ, 1023, 7, 0, '0));
    push_item(make_item(MODE_READ, 1022, 3, 0, '0));
    // Start pointer past the table, and an end pointer of zero
    push_item(make_item(MODE_LOAD_ROW, 1, 0, NUM_SLOTS, '0));
    push_item(make_item(MODE_LOAD_ROW, 2, 0, 8200, '0));
    push_item(make_item(MODE_LOAD_ROW, 3, 0, 0, '0));
    push_item(make_item(MODE_READ, 1, 0, 0, '0));
    push_item(make_item(MODE_ADD, 2, 1, 0, ADD_MAX));

    // Random part: mostly accesses into a loaded band, the rest noise
    done = 0;
    while (done < RANDOM_ITEMS) begin
      if (done % BAND_PERIOD == 0) build_band();
      steady = (done >= 400 && done < 650);
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        // Band row: a listed column, or any column below the diagonal
        k = $urandom_range(0, band_count - 1);
        r = band_first + k;
        if (kind < 45 && band_len[k] > 0) c = band_cols[k][$urandom_range(0, band_len[k] - 1)];
        else c = (r > 0) ? $urandom_range(0, r - 1) : 0;
        if ($urandom_range(0, 1)) push_offdiag(c, r);
        else push_offdiag(r, c);
        done++;
      end else if (kind < 75) begin
        r = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, NUM_ROWS - 1);
        push_item(make_item(pick_access(), r, r, $urandom_range(0, 16383), random_addend()));
        done++;
      end else if (kind < 83) begin
        push_item(make_item(pick_access(), $urandom_range(NUM_ROWS, 2047),
                            $urandom_range(0, 1023), $urandom_range(0, 16383),
                            random_addend()));
        done++;
      end else if (kind < 91) begin
        // Ignored loads
        if ($urandom_range(0, 1))
          push_item(make_item(MODE_LOAD_ROW, $urandom_range(NUM_ROWS + 1, 2047),
                              $urandom_range(0, 1023), $urandom_range(0, 16383),
                              random_addend()));
        else
          push_item(make_item(MODE_LOAD_COL, $urandom_range(0, 2047), $urandom_range(0, 1023),
                              $urandom_range(NUM_SLOTS, 16383), random_addend()));
      end else if (kind < 94) begin
        // Overwrite one column slot of the band, breaking its ordering
        lo = rs_sh[band_first];
        hi = rs_sh[band_first + band_count];
        if (hi > NUM_SLOTS) hi = NUM_SLOTS;
        if (hi > lo) begin
          push_item(make_item(MODE_LOAD_COL, $urandom_range(0, 2047), $urandom_range(0, 1023),
                              $urandom_range(lo, hi - 1), random_addend()));
          done++;
        end
      end else begin
        push_offdiag($urandom_range(0, NUM_ROWS - 1), $urandom_range(0, NUM_ROWS - 1));
        done++;
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
